// ===== rtl/core/block_transfer_sequencer_top_macros.svh =====
// assertion macros for the block transfer sequencer
`ifndef BLOCK_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define BLOCK_TRANSFER_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication under reset
`define BTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bts implication check failed");

// next-cycle implication under reset
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bts next-cycle check failed");

`else

`define BTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/bts_pkg.sv =====
// types, constants and helpers shared by the block transfer sequencer
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int CNT_W     = $clog2(REG_COUNT + 1);
    localparam int ADDR_W    = 32;

    localparam logic [ADDR_W-1:0] WORD_STEP  = 32'd4;
    localparam logic [ADDR_W-1:0] EMPTY_SPAN = 32'h40;

    localparam logic [REG_IDX_W-1:0] PC_REG = 4'd15;

    localparam logic [1:0] SRC_REG        = 2'd0;
    localparam logic [1:0] SRC_BASE_ORIG  = 2'd1;
    localparam logic [1:0] SRC_BASE_FINAL = 2'd2;
    localparam logic [1:0] SRC_PC_PLUS4   = 2'd3;

    typedef struct packed {
        logic                  pre;
        logic                  up;
        logic                  wb;
        logic                  wb_en;
        logic                  load;
        logic                  ubank;
        logic                  rstat;
        logic                  empty;
        logic [REG_IDX_W-1:0]  rn;
        logic [REG_COUNT-1:0]  list;
        logic [CNT_W-1:0]      cnt;
        logic [ADDR_W-1:0]     base;
    } bts_dec_t;

    typedef struct packed {
        logic                  pre;
        logic                  wb;
        logic                  wb_en;
        logic                  load;
        logic                  ubank;
        logic                  rstat;
        logic                  empty;
        logic [REG_IDX_W-1:0]  rn;
        logic [REG_COUNT-1:0]  list;
        logic [ADDR_W-1:0]     start;
        logic [ADDR_W-1:0]     end_address;
    } bts_ins_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     address;
        logic [REG_IDX_W-1:0]  reg_num;
        logic                  load_access;
        logic [1:0]            store_source;
        logic                  writeback_enable;
        logic [ADDR_W-1:0]     writeback_value;
        logic                  user_bank;
        logic                  restore_status;
        logic                  last;
    } bts_xfer_t;

    // adder tree population count
    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [1:0] l1 [8];
        logic [2:0] l2 [4];
        logic [3:0] l3 [2];
        for (int i = 0; i < 8; i++)
        begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        return {1'b0, l3[0]} + {1'b0, l3[1]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bts_decode.sv =====
// first stage: register list decode, count and mode flags
`timescale 1ns / 1ps
`default_nettype none

module bts_decode
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              pre_index,
    input  wire logic                              ascending,
    input  wire logic                              user_bank_req,
    input  wire logic                              write_back,
    input  wire logic                              is_load,
    input  wire logic [bts_pkg::REG_IDX_W-1:0]     base_reg,
    input  wire logic [bts_pkg::REG_COUNT-1:0]     reg_list,
    input  wire logic [bts_pkg::ADDR_W-1:0]        base_value,
    output logic                                   dec_valid,
    input  wire logic                              dec_ready,
    output bts_pkg::bts_dec_t                      dec
);

    logic              valid_reg;
    logic              valid_next;
    bts_pkg::bts_dec_t dec_reg;
    bts_pkg::bts_dec_t dec_next;
    logic              empty;
    logic              has_pc;
    logic              base_listed;

    assign in_ready  = !valid_reg || dec_ready;
    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

    always_comb
    begin
        empty       = (reg_list == '0);
        has_pc      = empty || reg_list[bts_pkg::REG_COUNT-1];
        base_listed = empty ? (base_reg == bts_pkg::PC_REG) : reg_list[base_reg];

        dec_next.pre   = ascending ? pre_index : !pre_index;
        dec_next.up    = ascending;
        dec_next.wb    = write_back;
        dec_next.wb_en = write_back && !(is_load && base_listed);
        dec_next.load  = is_load;
        dec_next.rstat = user_bank_req && is_load && has_pc;
        dec_next.ubank = user_bank_req && !(is_load && has_pc);
        dec_next.empty = empty;
        dec_next.rn    = base_reg;
        dec_next.list  = empty ? {1'b1, {(bts_pkg::REG_COUNT-1){1'b0}}} : reg_list;
        dec_next.cnt   = bts_pkg::popcount16(reg_list);
        dec_next.base  = base_value;

        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dec_reg <= dec_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bts_addr.sv =====
// second stage: span, final address and start address
`timescale 1ns / 1ps
`default_nettype none

module bts_addr
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          dec_valid,
    output logic               dec_ready,
    input  bts_pkg::bts_dec_t  dec,
    output logic               ins_valid,
    input  wire logic          ins_ready,
    output bts_pkg::bts_ins_t  ins
);

    logic                         valid_reg;
    logic                         valid_next;
    bts_pkg::bts_ins_t            ins_reg;
    bts_pkg::bts_ins_t            ins_next;
    logic [bts_pkg::ADDR_W-1:0]   span;
    logic [bts_pkg::ADDR_W-1:0]   end_address;

    assign dec_ready = !valid_reg || ins_ready;
    assign ins_valid = valid_reg;
    assign ins       = ins_reg;

    always_comb
    begin
        span = dec.empty ? bts_pkg::EMPTY_SPAN
                         : {{(bts_pkg::ADDR_W-bts_pkg::CNT_W-2){1'b0}}, dec.cnt, 2'b00};
        end_address = dec.up ? (dec.base + span) : (dec.base - span);

        ins_next.pre         = dec.pre;
        ins_next.wb          = dec.wb;
        ins_next.wb_en       = dec.wb_en;
        ins_next.load        = dec.load;
        ins_next.ubank       = dec.ubank;
        ins_next.rstat       = dec.rstat;
        ins_next.empty       = dec.empty;
        ins_next.rn          = dec.rn;
        ins_next.list        = dec.list;
        ins_next.start       = dec.up ? dec.base : end_address;
        ins_next.end_address = end_address;

        valid_next = valid_reg;
        if (dec_ready)
        begin
            valid_next = dec_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_valid && dec_ready)
        begin
            ins_reg <= ins_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bts_seq.sv =====
// transfer sequencer: walks the register list and drives the output register
`timescale 1ns / 1ps
`default_nettype none

module bts_seq
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          ins_valid,
    output logic               ins_ready,
    input  bts_pkg::bts_ins_t  ins,
    output logic               out_valid,
    input  wire logic          out_stall,
    output bts_pkg::bts_xfer_t xfer
);

    logic                              seq_valid_reg;
    logic                              seq_valid_next;
    bts_pkg::bts_ins_t                 cur_reg;
    logic [bts_pkg::REG_COUNT-1:0]     rem_reg;
    logic [bts_pkg::REG_COUNT-1:0]     rem_next;
    logic [bts_pkg::ADDR_W-1:0]        run_reg;
    logic [bts_pkg::ADDR_W-1:0]        run_next;
    logic                              first_reg;
    logic                              first_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    bts_pkg::bts_xfer_t                xfer_reg;
    bts_pkg::bts_xfer_t                xfer_next;
    logic                              emit;
    logic                              load_ins;
    logic                              cur_last;
    logic [bts_pkg::REG_COUNT-1:0]     rem_after;
    logic [bts_pkg::REG_IDX_W-1:0]     idx;
    logic [1:0]                        src;

    assign out_valid = out_valid_reg;
    assign xfer      = xfer_reg;

    always_comb
    begin
        idx = '0;
        for (int i = bts_pkg::REG_COUNT - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                idx = bts_pkg::REG_IDX_W'(i);
            end
        end

        rem_after = rem_reg & (rem_reg - 1'b1);
        cur_last  = (rem_after == '0);
        emit      = seq_valid_reg && (!out_valid_reg || !out_stall);
        ins_ready = !seq_valid_reg || (emit && cur_last);
        load_ins  = ins_valid && ins_ready;

        priority if (cur_reg.load)
        begin
            src = bts_pkg::SRC_REG;
        end
        else if (cur_reg.empty)
        begin
            src = bts_pkg::SRC_PC_PLUS4;
        end
        else if (idx == cur_reg.rn)
        begin
            src = (first_reg || !cur_reg.wb) ? bts_pkg::SRC_BASE_ORIG
                                             : bts_pkg::SRC_BASE_FINAL;
        end
        else if (idx == bts_pkg::PC_REG)
        begin
            src = bts_pkg::SRC_PC_PLUS4;
        end
        else
        begin
            src = bts_pkg::SRC_REG;
        end

        xfer_next.address          = cur_reg.pre ? (run_reg + bts_pkg::WORD_STEP) : run_reg;
        xfer_next.reg_num          = idx;
        xfer_next.load_access      = cur_reg.load;
        xfer_next.store_source     = src;
        xfer_next.writeback_enable = cur_last && cur_reg.wb_en;
        xfer_next.writeback_value  = cur_last ? cur_reg.end_address : '0;
        xfer_next.user_bank        = cur_reg.ubank;
        xfer_next.restore_status   = cur_reg.rstat;
        xfer_next.last             = cur_last;

        seq_valid_next = seq_valid_reg;
        rem_next       = rem_reg;
        run_next       = run_reg;
        first_next     = first_reg;
        if (load_ins)
        begin
            seq_valid_next = 1'b1;
            rem_next       = ins.list;
            run_next       = ins.start;
            first_next     = 1'b1;
        end
        else if (emit)
        begin
            seq_valid_next = !cur_last;
            rem_next       = rem_after;
            run_next       = run_reg + bts_pkg::WORD_STEP;
            first_next     = cur_last;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            rem_reg       <= '0;
            run_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_valid_reg <= seq_valid_next;
            rem_reg       <= rem_next;
            run_reg       <= run_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ins)
        begin
            cur_reg <= ins;
        end
        if (emit)
        begin
            xfer_reg <= xfer_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/block_transfer_sequencer_top.sv =====
// top level of the load/store-multiple block transfer sequencer
`timescale 1ns / 1ps
`default_nettype none

// Takes one load/store-multiple instruction per transaction on the instr
// channel and issues one transfer per listed register, lowest register first,
// on the xfer channel; the final transfer carries last, the writeback flag and
// the final base address. The sequencer emits one transfer per cycle while
// xfer_stall is low, issuing one per listed register (one for an empty list, at
// most 16); that walk through the register list sets the sustained rate. Two
// decode stages ahead of it overlap the next instruction, which is registered
// in decode, address and sequencer before its first transfer is registered out.

`include "block_transfer_sequencer_top_macros.svh"

module block_transfer_sequencer_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              instr_valid,
    output logic                                   instr_stall,
    input  wire logic                              pre_index,
    input  wire logic                              ascending,
    input  wire logic                              user_bank_req,
    input  wire logic                              write_back,
    input  wire logic                              is_load,
    input  wire logic [bts_pkg::REG_IDX_W-1:0]     base_reg,
    input  wire logic [bts_pkg::REG_COUNT-1:0]     reg_list,
    input  wire logic [bts_pkg::ADDR_W-1:0]        base_value,
    output logic                                   xfer_valid,
    input  wire logic                              xfer_stall,
    output logic [bts_pkg::ADDR_W-1:0]             address,
    output logic [bts_pkg::REG_IDX_W-1:0]          reg_num,
    output logic                                   load_access,
    output logic [1:0]                             store_source,
    output logic                                   writeback_enable,
    output logic [bts_pkg::ADDR_W-1:0]             writeback_value,
    output logic                                   user_bank,
    output logic                                   restore_status,
    output logic                                   last
);

    logic               in_ready;
    logic               dec_valid;
    logic               dec_ready;
    bts_pkg::bts_dec_t  dec;
    logic               ins_valid;
    logic               ins_ready;
    bts_pkg::bts_ins_t  ins;
    bts_pkg::bts_xfer_t xfer;

    assign instr_stall = !in_ready;

    bts_decode u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (instr_valid),
        .in_ready      (in_ready),
        .pre_index     (pre_index),
        .ascending     (ascending),
        .user_bank_req (user_bank_req),
        .write_back    (write_back),
        .is_load       (is_load),
        .base_reg      (base_reg),
        .reg_list      (reg_list),
        .base_value    (base_value),
        .dec_valid     (dec_valid),
        .dec_ready     (dec_ready),
        .dec           (dec)
    );

    bts_addr u_addr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .ins_valid (ins_valid),
        .ins_ready (ins_ready),
        .ins       (ins)
    );

    bts_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ins_valid (ins_valid),
        .ins_ready (ins_ready),
        .ins       (ins),
        .out_valid (xfer_valid),
        .out_stall (xfer_stall),
        .xfer      (xfer)
    );

    assign address          = xfer.address;
    assign reg_num          = xfer.reg_num;
    assign load_access      = xfer.load_access;
    assign store_source     = xfer.store_source;
    assign writeback_enable = xfer.writeback_enable;
    assign writeback_value  = xfer.writeback_value;
    assign user_bank        = xfer.user_bank;
    assign restore_status   = xfer.restore_status;
    assign last             = xfer.last;

    // writeback only on the closing transfer
    `BTS_ASSERT_IMPLY(a_wb_on_last, clk, rst_n, xfer_valid && writeback_enable, last)

    // a transaction that is not the last is followed at once by the next transfer
    `BTS_ASSERT_NEXT(a_no_gap, clk, rst_n, xfer_valid && !xfer_stall && !last, xfer_valid)

    // consecutive transfers of one instruction step by one word
    `BTS_ASSERT_NEXT(a_addr_step, clk, rst_n, xfer_valid && !xfer_stall && !last, address == $past(address) + bts_pkg::WORD_STEP)

    // registers go out lowest first
    `BTS_ASSERT_NEXT(a_reg_order, clk, rst_n, xfer_valid && !xfer_stall && !last, reg_num > $past(reg_num))

endmodule

`default_nettype wire
